### hw/rtl/wsc_pkg.sv
// shared constants and controller/datapath interface types for the window statistics block
package wsc_pkg;

  localparam int VOLT_W      = 13;
  localparam int GAIN_W      = 20;
  localparam int GAIN_FRAC   = 16;
  localparam int DIST_W      = 14;
  localparam int QUO_W       = 14;
  localparam int PROD_W      = VOLT_W + GAIN_W;

  localparam logic [DIST_W-1:0] DIST_MAX  = 14'd16383;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd177558;

  localparam int WSC_WINDOW_SAMPLES = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic scale;
    logic accum;
    logic prod;
    logic diff;
    logic sqrt_step;
    logic div_load;
    logic out_load;
    logic close;
  } wsc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;
  } wsc_status_t;

endpackage

### hw/rtl/wsc_cdiv.sv
// division by a fixed divisor through multiplication by its rounded-up reciprocal
module wsc_cdiv
  import wsc_pkg::*;
#(
  parameter int DIVISOR    = WSC_WINDOW_SAMPLES,
  parameter int DIVIDEND_W = DIST_W + $clog2(WSC_WINDOW_SAMPLES)
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic [QUO_W-1:0]      quotient
);

  // shifting by dividend width plus ceil(log2 divisor) keeps the rounding
  // error below one quotient step over the whole dividend range
  localparam int                SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int                RECIP_W = DIVIDEND_W + 1;
  localparam int                MUL_W   = DIVIDEND_W + RECIP_W;
  localparam longint unsigned   RECIP   =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [MUL_W-1:0] mul;
  logic [QUO_W-1:0] quo_r;
  logic [QUO_W-1:0] quo_nxt;

  assign mul     = MUL_W'(dividend) * MUL_W'(RECIP_C);
  assign quo_nxt = load ? mul[SHIFT +: QUO_W] : quo_r;

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

### hw/rtl/wsc_datapath.sv
// scaling, accumulators, square root and output registers
module wsc_datapath
  import wsc_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WSC_WINDOW_SAMPLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wsc_cmd_t           cmd,
  output wsc_status_t        status,
  input  logic [VOLT_W-1:0]  in_voltage_mv,
  input  logic               cfg_wr_en,
  input  logic [GAIN_W-1:0]  cfg_wr_data,
  output logic [DIST_W-1:0]  out_distance_mm,
  output logic               out_window_done,
  output logic [DIST_W-1:0]  out_window_mean,
  output logic [DIST_W-1:0]  out_window_max,
  output logic [DIST_W-1:0]  out_window_min,
  output logic [DIST_W-1:0]  out_window_deviation
);

  localparam int LOG_N  = $clog2(WINDOW_SAMPLES);
  localparam int POS_W  = LOG_N;
  localparam int SUM_W  = DIST_W + LOG_N;
  localparam int SQ_W   = 2 * DIST_W + LOG_N;
  localparam int DIFF_W = 2 * SUM_W;
  localparam int ROOT_W = SUM_W;
  localparam int REM_W  = ROOT_W + 2;

  logic [GAIN_W-1:0]     gain_r;
  logic [PROD_W-1:0]     prod_r;
  logic [DIST_W-1:0]     dist_r;
  logic [POS_W-1:0]      pos_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SQ_W-1:0]       sq_r;
  logic [DIST_W-1:0]     max_r;
  logic [DIST_W-1:0]     min_r;
  logic [DIFF_W-1:0]     nsq_r;
  logic [DIFF_W-1:0]     ssq_r;
  logic [DIFF_W-1:0]     rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;

  logic [PROD_W-GAIN_FRAC-1:0] scaled;
  logic [2*DIST_W-1:0]         dist_sq;
  logic [REM_W-1:0]            rem_sh;
  logic [REM_W-1:0]            trial;
  logic [QUO_W-1:0]            mean_q;
  logic [QUO_W-1:0]            dev_q;
  logic                        pos_last;

  assign scaled   = prod_r[PROD_W-1:GAIN_FRAC];
  assign dist_sq  = (2*DIST_W)'(dist_r) * (2*DIST_W)'(dist_r);
  assign pos_last = (pos_r == POS_W'(WINDOW_SAMPLES - 1));
  assign status.last = pos_last;

  // one result digit per step: bring down two radicand bits, try 4q+1
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[DIFF_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      max_r <= '0;
      min_r <= '0;
    end else if (cmd.accum) begin
      pos_r <= pos_last ? '0 : pos_r + POS_W'(1);
      sum_r <= sum_r + SUM_W'(dist_r);
      sq_r  <= sq_r + SQ_W'(dist_sq);
      if (pos_r == '0) begin
        max_r <= dist_r;
        min_r <= dist_r;
      end else begin
        if (dist_r > max_r) max_r <= dist_r;
        if (dist_r < min_r) min_r <= dist_r;
      end
    end else if (cmd.out_load && cmd.close) begin
      sum_r <= '0;
      sq_r  <= '0;
    end
  end

  // scaling, products and square root
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_r <= PROD_W'(in_voltage_mv) * PROD_W'(gain_r);
    end
    if (cmd.scale) begin
      dist_r <= (scaled > (PROD_W-GAIN_FRAC)'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
    end
    if (cmd.prod) begin
      nsq_r <= DIFF_W'(sq_r) * DIFF_W'(WINDOW_SAMPLES);
      ssq_r <= DIFF_W'(sum_r) * DIFF_W'(sum_r);
    end
    if (cmd.diff) begin
      rad_r  <= (nsq_r > ssq_r) ? nsq_r - ssq_r : '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  wsc_cdiv #(
    .DIVISOR    (WINDOW_SAMPLES),
    .DIVIDEND_W (SUM_W)
  ) u_mean_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .dividend (sum_r),
    .quotient (mean_q)
  );

  wsc_cdiv #(
    .DIVISOR    (WINDOW_SAMPLES),
    .DIVIDEND_W (ROOT_W)
  ) u_dev_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .dividend (root_r),
    .quotient (dev_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_distance_mm      <= dist_r;
      out_window_done      <= cmd.close;
      out_window_mean      <= cmd.close ? mean_q : '0;
      out_window_max       <= cmd.close ? max_r : '0;
      out_window_min       <= cmd.close ? min_r : '0;
      out_window_deviation <= cmd.close ? dev_q : '0;
    end
  end

`ifndef SYNTHESIS
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0) |-> (min_r <= max_r))
    else $error("window min above window max");
`endif

endmodule

### hw/rtl/wsc_ctrl.sv
// sequencing state machine for the window statistics block
module wsc_ctrl
  import wsc_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WSC_WINDOW_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output wsc_cmd_t    cmd,
  input  wsc_status_t status
);

  localparam int ROOT_W = DIST_W + $clog2(WINDOW_SAMPLES);
  localparam int STEP_W = $clog2(ROOT_W);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SCALE = 8'b00000010,
    ST_ACCUM = 8'b00000100,
    ST_PROD  = 8'b00001000,
    ST_DIFF  = 8'b00010000,
    ST_SQRT  = 8'b00100000,
    ST_DLOAD = 8'b01000000,
    ST_OUT   = 8'b10000000
  } wsc_state_t;

  wsc_state_t        state_r;
  wsc_state_t        state_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic [STEP_W-1:0] cnt_nxt;
  logic              close_r;
  logic              close_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.capture   = (state_r == ST_IDLE) && in_valid;
  assign cmd.scale     = (state_r == ST_SCALE);
  assign cmd.accum     = (state_r == ST_ACCUM);
  assign cmd.prod      = (state_r == ST_PROD);
  assign cmd.diff      = (state_r == ST_DIFF);
  assign cmd.sqrt_step = (state_r == ST_SQRT);
  assign cmd.div_load  = (state_r == ST_DLOAD);
  assign cmd.out_load  = (state_r == ST_OUT) && out_free;
  assign cmd.close     = close_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    close_nxt = close_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        close_nxt = status.last;
        state_nxt = status.last ? ST_PROD : ST_OUT;
      end
      ST_PROD: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cnt_nxt   = STEP_W'(ROOT_W - 1);
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DLOAD;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      ST_DLOAD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      close_r     <= close_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result beat raised outside the output state");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !cmd.out_load ##1 !cmd.out_load)
    else $error("result loaded before the sample was scaled and accumulated");

  a_sqrt_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> close_r)
    else $error("statistics sequence running on a sample that does not close a window");
`endif

endmodule

### hw/rtl/sonar_window_statistics_top.sv
// top level of the sonar window statistics block
//
// each input beat carries a sonar voltage in millivolts; it is scaled to a
// distance in millimetres by the Q4.16 gain register (floor of voltage times
// gain over 65536, saturated at 16383) and gives exactly one result beat.
// distance sum, sum of squares, min and max are kept per window of
// WINDOW_SAMPLES samples; the first sample of a window reloads min and max.
// the beat that closes a window also carries window_done, the mean, min,
// max and the standard deviation floor(isqrt(N*sumsq - sum^2) / N), and the
// sums clear; other beats carry zeros in the statistics fields.
// one sample is worked on at a time: an ordinary sample goes from input beat
// to result register through capture multiply, saturate, accumulate and
// output load. a window-closing sample also runs the products, the
// difference, the bit-per-step square root over the variance term and the
// divider load, where mean and deviation each come from one multiplication
// by the reciprocal of N. the result register lets the next sample be taken
// while a finished beat still waits downstream. the gain register is to be
// written by the user with cfg_wr_en/cfg_wr_data only while no sample is in
// flight; the block itself does not enforce this.
module sonar_window_statistics_top
  import wsc_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WSC_WINDOW_SAMPLES
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VOLT_W-1:0] in_voltage_mv,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] out_distance_mm,
  output logic              out_window_done,
  output logic [DIST_W-1:0] out_window_mean,
  output logic [DIST_W-1:0] out_window_max,
  output logic [DIST_W-1:0] out_window_min,
  output logic [DIST_W-1:0] out_window_deviation,
  // gain register write port
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data
);

  wsc_cmd_t    cmd;
  wsc_status_t status;

  // sequencer: handshakes and step counting
  wsc_ctrl #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic, window state and result register
  wsc_datapath #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_voltage_mv        (in_voltage_mv),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_distance_mm      (out_distance_mm),
    .out_window_done      (out_window_done),
    .out_window_mean      (out_window_mean),
    .out_window_max       (out_window_max),
    .out_window_min       (out_window_min),
    .out_window_deviation (out_window_deviation)
  );

endmodule
